// ----- hdl/swsr_pkg.sv -----
package swsr_pkg;

  localparam int unsigned WinnerW = 32;
  localparam int unsigned TickW   = 32;
  localparam int unsigned StreakW = 18;
  localparam int unsigned CfgW    = 16;
  localparam int unsigned FracW   = 16;
  localparam int unsigned StaleW  = FracW + 1;
  localparam int unsigned InDataW  = WinnerW + TickW;
  localparam int unsigned OutPackW = StaleW + TickW;
  localparam int unsigned OutDataW = ((OutPackW + 7) / 8) * 8;
  localparam int unsigned CntW     = $clog2(FracW + 1);

  localparam logic [StreakW-1:0] StreakMax   = '1;
  localparam logic [StaleW-1:0]  StaleOne    = StaleW'(1) << FracW;
  localparam logic [CfgW-1:0]    ThreshReset = CfgW'(60);
  localparam logic [CfgW-1:0]    WindowReset = CfgW'(240);

  typedef enum logic [1:0] {
    REG_THRESHOLD = 2'd0,
    REG_WINDOW    = 2'd1,
    REG_EMIT_ZERO = 2'd2
  } cfg_reg_e;

  typedef enum logic {
    CMD_REPORT = 1'b0,
    CMD_TICK   = 1'b1
  } cmd_e;

  typedef enum logic [3:0] {
    S_IDLE = 4'b0001,
    S_CALC = 4'b0010,
    S_DIV  = 4'b0100,
    S_OUT  = 4'b1000
  } state_e;

  typedef struct packed {
    logic busy;
    logic done;
  } div_stat_t;

endpackage

// ----- hdl/swsr_div.sv -----
// Restoring divider, one quotient bit per cycle: quot = floor(num * 2^FracW / den),
// valid for num < den.
module swsr_div (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       start_i,
  input  logic [swsr_pkg::CfgW-1:0]  num_i,
  input  logic [swsr_pkg::CfgW-1:0]  den_i,
  output swsr_pkg::div_stat_t        stat_o,
  output logic [swsr_pkg::FracW-1:0] quot_o
);
  import swsr_pkg::*;

  logic [CntW-1:0]  cnt_q, cnt_d;
  logic             done_q, done_d;
  logic [CfgW-1:0]  rem_q, rem_d;
  logic [CfgW-1:0]  den_q, den_d;
  logic [FracW-1:0] quot_q, quot_d;
  logic [CfgW:0]    shifted;
  logic [CfgW:0]    trial;
  logic             fits;

  always_comb begin
    shifted = {rem_q, 1'b0};
    trial   = shifted - {1'b0, den_q};
    fits    = shifted >= {1'b0, den_q};
    cnt_d   = cnt_q;
    rem_d   = rem_q;
    den_d   = den_q;
    quot_d  = quot_q;
    done_d  = 1'b0;
    if (start_i) begin
      cnt_d  = CntW'(FracW);
      rem_d  = num_i;
      den_d  = den_i;
      quot_d = '0;
    end else if (cnt_q != '0) begin
      // remainder stays below den, so the low bits hold it
      rem_d  = fits ? trial[CfgW-1:0] : shifted[CfgW-1:0];
      quot_d = {quot_q[FracW-2:0], fits};
      cnt_d  = cnt_q - CntW'(1);
      done_d = (cnt_q == CntW'(1));
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q  <= '0;
      done_q <= 1'b0;
    end else begin
      cnt_q  <= cnt_d;
      done_q <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q  <= rem_d;
    den_q  <= den_d;
    quot_q <= quot_d;
  end

  assign stat_o.busy = (cnt_q != '0);
  assign stat_o.done = done_q;
  assign quot_o      = quot_q;

endmodule

// ----- hdl/same_winner_staleness_ramp.sv -----
// Same-winner staleness ramp. A report beat (tuser = 0) latches a winner id and
// keeps the block idle. A tick beat (tuser = 1) folds the pending report into
// the streak and produces staleness = clamp((streak - idle_threshold) /
// decay_window, 0, 1) in Q1.16, or zero when decay_window is 0; a result beat
// follows when staleness is nonzero or emit_when_zero is set. A tick whose ramp
// is clamped at either end skips the divider; otherwise the bit-serial divider
// retires one quotient bit per cycle over 16 fraction bits. The output register
// lets the block take the next beat while a result waits; a tick that finishes
// while the previous result is still held waits for it.
module same_winner_staleness_ramp (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [1:0]                    cfg_idx_i,
  input  logic [swsr_pkg::CfgW-1:0]     cfg_wdata_i,
  input  logic                          s_axis_tvalid_i,
  output logic                          s_axis_tready_o,
  input  logic [swsr_pkg::InDataW-1:0]  s_axis_tdata_i,  // winner, tick number
  input  logic                          s_axis_tuser_i,  // command
  output logic                          m_axis_tvalid_o,
  input  logic                          m_axis_tready_i,
  output logic [swsr_pkg::OutDataW-1:0] m_axis_tdata_o,  // staleness, tick_echo, zero pad
  output logic                          m_axis_tuser_o   // active
);
  import swsr_pkg::*;

  state_e              state_q, state_d;
  logic [CfgW-1:0]     thresh_q, window_q;
  logic                emit_zero_q;
  logic [WinnerW-1:0]  pend_q, cur_q;
  logic                seen_q;
  logic [StreakW-1:0]  streak_q;
  logic [TickW-1:0]    tick_q;
  logic [StaleW-1:0]   stale_q, stale_d;
  logic                out_valid_q, out_valid_d;
  logic [StaleW-1:0]   out_stale_q;
  logic [TickW-1:0]    out_tick_q;
  logic                accept, load_out, div_start;
  logic [StreakW:0]    over;
  logic                over_pos, over_full;
  div_stat_t           div_stat;
  logic [FracW-1:0]    div_quot;

  assign accept = s_axis_tvalid_i && s_axis_tready_o;
  assign s_axis_tready_o = (state_q == S_IDLE);

  assign over      = {1'b0, streak_q} - (StreakW + 1)'(thresh_q);
  assign over_pos  = (streak_q > StreakW'(thresh_q));
  assign over_full = over[StreakW-1:0] >= StreakW'(window_q);

  assign load_out = (state_q == S_OUT) && (!out_valid_q || m_axis_tready_i);

  always_comb begin
    state_d   = state_q;
    stale_d   = stale_q;
    div_start = 1'b0;
    unique case (state_q)
      S_IDLE: if (accept && s_axis_tuser_i == CMD_TICK) state_d = S_CALC;
      S_CALC: begin
        if (!over_pos || window_q == '0) begin
          stale_d = '0;
          state_d = S_OUT;
        end else if (over_full) begin
          stale_d = StaleOne;
          state_d = S_OUT;
        end else begin
          div_start = 1'b1;
          state_d   = S_DIV;
        end
      end
      S_DIV: begin
        if (div_stat.done) begin
          stale_d = {1'b0, div_quot};
          state_d = S_OUT;
        end
      end
      S_OUT: if (load_out) state_d = S_IDLE;
      default: state_d = S_IDLE;
    endcase
  end

  always_comb begin
    out_valid_d = out_valid_q && !m_axis_tready_i;
    if (load_out && (stale_q != '0 || emit_zero_q)) out_valid_d = 1'b1;
  end

  swsr_div u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (div_start),
    .num_i   (over[CfgW-1:0]),
    .den_i   (window_q),
    .stat_o  (div_stat),
    .quot_o  (div_quot)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      thresh_q    <= ThreshReset;
      window_q    <= WindowReset;
      emit_zero_q <= 1'b0;
      pend_q      <= '0;
      seen_q      <= 1'b0;
      cur_q       <= '0;
      streak_q    <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
      if (cfg_we_i) begin
        unique case (cfg_idx_i)
          REG_THRESHOLD: thresh_q    <= cfg_wdata_i;
          REG_WINDOW:    window_q    <= cfg_wdata_i;
          REG_EMIT_ZERO: emit_zero_q <= cfg_wdata_i[0];
          default: ;
        endcase
      end
      if (accept) begin
        if (s_axis_tuser_i == CMD_REPORT) begin
          pend_q <= s_axis_tdata_i[WinnerW-1:0];
          seen_q <= 1'b1;
        end else if (seen_q) begin
          seen_q <= 1'b0;
          if (pend_q != cur_q) begin
            cur_q    <= pend_q;
            streak_q <= '0;
          end else if (streak_q != StreakMax) begin
            streak_q <= streak_q + StreakW'(1);
          end
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    stale_q <= stale_d;
    if (accept) tick_q <= s_axis_tdata_i[InDataW-1:WinnerW];
    if (load_out) begin
      out_stale_q <= stale_q;
      out_tick_q  <= tick_q;
    end
  end

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = {{(OutDataW - OutPackW){1'b0}}, out_tick_q, out_stale_q};
  assign m_axis_tuser_o  = (out_stale_q != '0);

endmodule

// ----- hdl/swsr_checker.sv -----
module swsr_checker (
  input logic                          clk_i,
  input logic                          rst_ni,
  input logic                          s_axis_tvalid_i,
  input logic                          s_axis_tready_o,
  input logic                          s_axis_tuser_i,
  input logic                          m_axis_tvalid_o,
  input logic                          m_axis_tready_i,
  input logic [swsr_pkg::OutDataW-1:0] m_axis_tdata_o,
  input logic                          m_axis_tuser_o
);
  import swsr_pkg::*;

  a_active_flag: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o |-> (m_axis_tuser_o == (m_axis_tdata_o[StaleW-1:0] != '0)))
    else $error("active flag disagrees with staleness");

  a_stale_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o |-> (m_axis_tdata_o[StaleW-1:0] <= StaleOne))
    else $error("staleness above 1.0");

  // a report never produces a result beat
  a_report_silent: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s_axis_tvalid_i && s_axis_tready_o && s_axis_tuser_i == CMD_REPORT)
      |=> !$rose(m_axis_tvalid_o))
    else $error("result beat after report");

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid_o && !m_axis_tready_i) |=> (m_axis_tvalid_o && $stable(m_axis_tdata_o)))
    else $error("stalled result beat changed");

endmodule

bind same_winner_staleness_ramp swsr_checker u_swsr_checker (
  .clk_i           (clk_i),
  .rst_ni          (rst_ni),
  .s_axis_tvalid_i (s_axis_tvalid_i),
  .s_axis_tready_o (s_axis_tready_o),
  .s_axis_tuser_i  (s_axis_tuser_i),
  .m_axis_tvalid_o (m_axis_tvalid_o),
  .m_axis_tready_i (m_axis_tready_i),
  .m_axis_tdata_o  (m_axis_tdata_o),
  .m_axis_tuser_o  (m_axis_tuser_o)
);
